### rtl/xds_pkg.sv
// Shared constants for the XOR distance shortlist: port widths, command,
// status and result kind codes, register indexes.
// No dependencies.
package xds_pkg;

  // fixed field widths at the ports
  localparam int ID_W       = 64;
  localparam int HANDLE_W   = 48;
  localparam int CC_W       = 7;
  localparam int CMD_W      = 3;
  localparam int KIND_W     = 2;
  localparam int FLY_W      = 5;
  localparam int CTR_W      = 32;
  localparam int PAR_W      = 5;
  localparam int K_W        = 7;
  localparam int IN_DATA_W  = 120;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 184;
  localparam int OUT_USER_W = 3;
  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 64;

  // result buffer
  localparam int MAX_RES   = 64;
  localparam int RES_AW    = 6;
  localparam int RES_CW    = 7;
  localparam int FLY_SAT   = 31;

  // commands
  localparam logic [CMD_W-1:0] CMD_ADD  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PICK = 3'd1;
  localparam logic [CMD_W-1:0] CMD_RESP = 3'd2;
  localparam logic [CMD_W-1:0] CMD_FAIL = 3'd3;
  localparam logic [CMD_W-1:0] CMD_READ = 3'd4;

  // entry status
  localparam logic [1:0] STS_UNQ  = 2'd0;
  localparam logic [1:0] STS_FLY  = 2'd1;
  localparam logic [1:0] STS_RESP = 2'd2;
  localparam logic [1:0] STS_FAIL = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_STATUS  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PICK    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CLOSEST = 2'd2;

  // register indexes
  localparam logic [1:0] REG_TARGET = 2'd0;
  localparam logic [1:0] REG_LOCAL  = 2'd1;
  localparam logic [1:0] REG_PAR    = 2'd2;
  localparam logic [1:0] REG_K      = 2'd3;

endpackage

### rtl/xds_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies; read data holds when no read is issued.
module xds_ram #(
  parameter int W = 8,
  parameter int D = 64
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic                 re,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/xor_distance_shortlist_core.sv
// Top level of the XOR distance shortlist: sequencer, registers, APB port.
// Depends on xds_pkg and xds_ram (entry table and result buffer).
//
// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    cmd, peer_id, peer_handle, closest_count
// out_     out  out_tvalid/out_tready  kind, peer, flags, counters
// cfg_     in   APB, pready always 1   target, own ID, alpha, K
//
// One request at a time. The entry table is walked through its single read port.
// Add takes a search pass, a shift of the farther entries (one per cycle) and
// one write, then the status pass; an Add of a duplicate, of the own ID or of a
// peer too far for a full table goes straight to the status pass. Other commands
// take the status pass only. Each result is read from the result buffer, then
// loaded into the output register; a status-only result is loaded directly. A
// target_id write re-sorts the table by insertion sort with in_tready low. Reset
// is synchronous; stalls on out_ hold the output register while the core waits.
module xor_distance_shortlist_core
  import xds_pkg::*;
#(
  parameter int CAPACITY     = 64,
  parameter int ID_WIDTH     = 64,
  parameter int HANDLE_WIDTH = 48,
  parameter int MAX_ALPHA    = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // peer_id[63:0], peer_handle[111:64], closest_count[118:112], zero[119]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // cmd[2:0]
  input  logic [IN_USER_W-1:0]  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // out_id[63:0], out_handle[111:64], complete[112], inflight_now[117:113],
  // success[118], overflowed[119], rpc_total[151:120], pick_rounds[183:152]
  output logic [OUT_DATA_W-1:0] out_tdata,
  // kind[1:0], peer_valid[2]
  output logic [OUT_USER_W-1:0] out_tuser,
  output logic                  out_tlast,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_AW-1:0]     cfg_paddr,
  input  logic [CFG_DW-1:0]     cfg_pwdata,
  output logic [CFG_DW-1:0]     cfg_prdata,
  output logic                  cfg_pready
);

  localparam int IW    = ID_WIDTH;
  localparam int HS_W  = (HANDLE_WIDTH < HANDLE_W) ? HANDLE_WIDTH : HANDLE_W;
  localparam int EW    = IW + HS_W + 2;
  localparam int RW    = IW + HS_W;
  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > 7) ? CNT_W : 7;

  typedef enum logic [3:0] {
    S_IDLE, S_SRT_KEY, S_SRT_CMP, S_SRT_PUT, S_ADD_SCAN, S_ADD_SHIFT,
    S_ADD_PUT, S_MAIN, S_EMIT_RD, S_EMIT_LD
  } state_t;

  state_t state_r, state_nxt;

  logic [CMD_W-1:0]      cmd_r, cmd_nxt;
  logic [IW-1:0]         pid_r, pid_nxt;
  logic [HS_W-1:0]       ph_r, ph_nxt;
  logic [RES_CW-1:0]     lim_r, lim_nxt;
  logic [CNT_W-1:0]      total_r, total_nxt;
  logic [CTR_W-1:0]      rpc_r, rpc_nxt;
  logic [CTR_W-1:0]      round_r, round_nxt;
  logic [CNT_W-1:0]      fly_r, fly_nxt;
  logic [IW-1:0]         target_r, target_nxt;
  logic [IW-1:0]         local_r, local_nxt;
  logic [PAR_W-1:0]      par_r, par_nxt;
  logic [K_W-1:0]        k_r, k_nxt;
  logic [CNT_W-1:0]      idx_r, idx_nxt;
  logic                  pend_r, pend_nxt;
  logic [AW-1:0]         pidx_r, pidx_nxt;
  logic [CNT_W-1:0]      i_r, i_nxt;
  logic [AW-1:0]         j_r, j_nxt;
  logic [EW-1:0]         key_r, key_nxt;
  logic                  dup_r, dup_nxt;
  logic                  found_r, found_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  over_r, over_nxt;
  logic [CNT_W-1:0]      ins_n_r, ins_n_nxt;
  logic [CNT_W-1:0]      rem_r, rem_nxt;
  logic [CNT_W-1:0]      pick_fly_r, pick_fly_nxt;
  logic [CNT_W-1:0]      fly_acc_r, fly_acc_nxt;
  logic [CNT_W-1:0]      resp_acc_r, resp_acc_nxt;
  logic [CNT_W-1:0]      unq_acc_r, unq_acc_nxt;
  logic [CNT_W-1:0]      seen_r, seen_nxt;
  logic [CNT_W-1:0]      respk_r, respk_nxt;
  logic                  preunq_r, preunq_nxt;
  logic [RES_CW-1:0]     res_n_r, res_n_nxt;
  logic [RES_AW-1:0]     e_r, e_nxt;
  logic                  comp_r, comp_nxt;
  logic                  succ_r, succ_nxt;
  logic [FLY_W-1:0]      flyo_r, flyo_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [OUT_USER_W-1:0] out_user_r, out_user_nxt;
  logic                  out_last_r, out_last_nxt;

  // memory ports
  logic              ent_we, ent_re;
  logic [AW-1:0]     ent_waddr, ent_raddr;
  logic [EW-1:0]     ent_wdata, ent_rdata;
  logic              res_we, res_re;
  logic [RES_AW-1:0] res_waddr, res_raddr;
  logic [RW-1:0]     res_wdata, res_rdata;

  // helpers
  logic              in_fire, cfg_wr, cfg_wr_target, out_free, start_main, next_i;
  logic [IW-1:0]     rd_node, key_node;
  logic [HS_W-1:0]   rd_hnd;
  logic [1:0]        rd_st, st_new;
  logic [IW-1:0]     dist_rd, dist_key, dist_new;
  logic [RES_CW-1:0] alpha;
  logic              full, emit_last;
  logic [CTR_W*2+3+FLY_W-1:0] tail;

  xds_ram #(.W(EW), .D(CAPACITY)) u_entries (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .re(ent_re), .raddr(ent_raddr), .rdata(ent_rdata)
  );

  xds_ram #(.W(RW), .D(MAX_RES)) u_results (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .re(res_re), .raddr(res_raddr), .rdata(res_rdata)
  );

  // handshakes
  assign cfg_pready    = 1'b1;
  assign cfg_wr        = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_wr_target = cfg_wr && (cfg_paddr[4:3] == REG_TARGET);
  assign in_tready     = (state_r == S_IDLE) && !cfg_wr_target;
  assign in_fire       = in_tvalid && in_tready;
  assign out_free      = !out_valid_r || out_tready;
  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign out_tuser     = out_user_r;
  assign out_tlast     = out_last_r;

  // register readback
  always_comb begin
    unique case (cfg_paddr[4:3])
      REG_TARGET: cfg_prdata = CFG_DW'(target_r);
      REG_LOCAL:  cfg_prdata = CFG_DW'(local_r);
      REG_PAR:    cfg_prdata = CFG_DW'(par_r);
      REG_K:      cfg_prdata = CFG_DW'(k_r);
      default:    cfg_prdata = '0;
    endcase
  end

  // entry fields and distances
  assign rd_node  = ent_rdata[EW-1 -: IW];
  assign rd_hnd   = ent_rdata[HS_W+1:2];
  assign rd_st    = ent_rdata[1:0];
  assign key_node = key_r[EW-1 -: IW];
  assign dist_rd  = rd_node ^ target_r;
  assign dist_key = key_node ^ target_r;
  assign dist_new = pid_r ^ target_r;
  assign full     = (total_r == CNT_W'(CAPACITY));

  // effective alpha
  always_comb begin
    alpha = (par_r == '0) ? RES_CW'(1) : RES_CW'(par_r);
    if (alpha > RES_CW'(MAX_ALPHA)) begin
      alpha = RES_CW'(MAX_ALPHA);
    end
  end

  // status fields shared by every result
  assign tail      = {round_r, rpc_r, over_r, succ_r, flyo_r, comp_r};
  assign emit_last = (RES_CW'(e_r) + RES_CW'(1)) == res_n_r;

  // per-entry status update during the status pass
  always_comb begin
    st_new = rd_st;
    unique case (cmd_r)
      CMD_PICK: begin
        if (rd_st == STS_UNQ && CW'(pick_fly_r) < CW'(alpha)
            && res_n_r < RES_CW'(MAX_RES)) begin
          st_new = STS_FLY;
        end
      end
      CMD_RESP: if (rd_node == pid_r) st_new = STS_RESP;
      CMD_FAIL: if (rd_node == pid_r) st_new = STS_FAIL;
      default:  st_new = rd_st;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cmd_nxt      = cmd_r;
    pid_nxt      = pid_r;
    ph_nxt       = ph_r;
    lim_nxt      = lim_r;
    total_nxt    = total_r;
    rpc_nxt      = rpc_r;
    round_nxt    = round_r;
    fly_nxt      = fly_r;
    target_nxt   = target_r;
    local_nxt    = local_r;
    par_nxt      = par_r;
    k_nxt        = k_r;
    idx_nxt      = idx_r;
    pend_nxt     = pend_r;
    pidx_nxt     = pidx_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    key_nxt      = key_r;
    dup_nxt      = dup_r;
    found_nxt    = found_r;
    pos_nxt      = pos_r;
    over_nxt     = over_r;
    ins_n_nxt    = ins_n_r;
    rem_nxt      = rem_r;
    pick_fly_nxt = pick_fly_r;
    fly_acc_nxt  = fly_acc_r;
    resp_acc_nxt = resp_acc_r;
    unq_acc_nxt  = unq_acc_r;
    seen_nxt     = seen_r;
    respk_nxt    = respk_r;
    preunq_nxt   = preunq_r;
    res_n_nxt    = res_n_r;
    e_nxt        = e_r;
    comp_nxt     = comp_r;
    succ_nxt     = succ_r;
    flyo_nxt     = flyo_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;
    out_data_nxt = out_data_r;
    out_user_nxt = out_user_r;
    out_last_nxt = out_last_r;
    ent_we       = 1'b0;
    ent_waddr    = '0;
    ent_wdata    = '0;
    ent_re       = 1'b0;
    ent_raddr    = '0;
    res_we       = 1'b0;
    res_waddr    = res_n_r[RES_AW-1:0];
    res_wdata    = {rd_node, rd_hnd};
    res_re       = 1'b0;
    res_raddr    = e_r;
    start_main   = 1'b0;
    next_i       = 1'b0;

    // register writes
    if (cfg_wr) begin
      unique case (cfg_paddr[4:3])
        REG_TARGET: target_nxt = cfg_pwdata[IW-1:0];
        REG_LOCAL:  local_nxt  = cfg_pwdata[IW-1:0];
        REG_PAR:    par_nxt    = cfg_pwdata[PAR_W-1:0];
        REG_K:      k_nxt      = cfg_pwdata[K_W-1:0];
        default:    ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (cfg_wr_target) begin
          // re-sort by the new distance
          if (total_r > CNT_W'(1)) begin
            ent_re    = 1'b1;
            ent_raddr = AW'(1);
            i_nxt     = CNT_W'(1);
            state_nxt = S_SRT_KEY;
          end
        end else if (in_fire) begin
          cmd_nxt  = in_tuser[CMD_W-1:0];
          pid_nxt  = in_tdata[IW-1:0];
          ph_nxt   = in_tdata[ID_W +: HS_W];
          lim_nxt  = (in_tdata[ID_W+HANDLE_W +: CC_W] > CC_W'(MAX_RES)) ?
                     RES_CW'(MAX_RES) : in_tdata[ID_W+HANDLE_W +: CC_W];
          over_nxt = 1'b0;
          if (in_tuser[CMD_W-1:0] == CMD_ADD) begin
            dup_nxt   = (in_tdata[IW-1:0] == local_r);
            found_nxt = 1'b0;
            pos_nxt   = total_r;
            idx_nxt   = '0;
            pend_nxt  = 1'b0;
            state_nxt = S_ADD_SCAN;
          end else begin
            start_main = 1'b1;
          end
        end
      end

      S_SRT_KEY: begin
        key_nxt   = ent_rdata;
        j_nxt     = i_r[AW-1:0];
        ent_re    = 1'b1;
        ent_raddr = AW'(i_r - CNT_W'(1));
        state_nxt = S_SRT_CMP;
      end

      S_SRT_CMP: begin
        if (dist_rd > dist_key) begin
          ent_we    = 1'b1;
          ent_waddr = j_r;
          ent_wdata = ent_rdata;
          j_nxt     = j_r - AW'(1);
          if (j_r != AW'(1)) begin
            ent_re    = 1'b1;
            ent_raddr = j_r - AW'(2);
          end else begin
            state_nxt = S_SRT_PUT;
          end
        end else begin
          ent_we    = 1'b1;
          ent_waddr = j_r;
          ent_wdata = key_r;
          next_i    = 1'b1;
        end
      end

      S_SRT_PUT: begin
        ent_we    = 1'b1;
        ent_waddr = '0;
        ent_wdata = key_r;
        next_i    = 1'b1;
      end

      // duplicate check and insert position
      S_ADD_SCAN: begin
        if (idx_r < total_r) begin
          ent_re    = 1'b1;
          ent_raddr = idx_r[AW-1:0];
          pidx_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (dist_rd == dist_new) dup_nxt = 1'b1;
          if (!found_r && dist_rd > dist_new) begin
            found_nxt = 1'b1;
            pos_nxt   = CNT_W'(pidx_r);
          end
        end else if (idx_r == total_r) begin
          if (dup_r) begin
            start_main = 1'b1;
          end else if (full && !found_r) begin
            over_nxt   = 1'b1;
            start_main = 1'b1;
          end else begin
            over_nxt  = full;
            ins_n_nxt = full ? CNT_W'(CAPACITY - 1) : total_r;
            rem_nxt   = (full ? CNT_W'(CAPACITY - 1) : total_r) - pos_r;
            idx_nxt   = (full ? CNT_W'(CAPACITY - 1) : total_r) - CNT_W'(1);
            pend_nxt  = 1'b0;
            state_nxt = S_ADD_SHIFT;
          end
        end
      end

      // move farther entries up by one, top first
      S_ADD_SHIFT: begin
        if (pend_r) begin
          ent_we    = 1'b1;
          ent_waddr = pidx_r + AW'(1);
          ent_wdata = ent_rdata;
        end
        if (rem_r != '0) begin
          ent_re    = 1'b1;
          ent_raddr = idx_r[AW-1:0];
          pidx_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_r - CNT_W'(1);
          rem_nxt   = rem_r - CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) state_nxt = S_ADD_PUT;
        end
      end

      S_ADD_PUT: begin
        ent_we     = 1'b1;
        ent_waddr  = pos_r[AW-1:0];
        ent_wdata  = {pid_r, ph_r, STS_UNQ};
        total_nxt  = ins_n_r + CNT_W'(1);
        start_main = 1'b1;
      end

      // status pass: apply the command and gather the summary
      S_MAIN: begin
        if (idx_r < total_r) begin
          ent_re    = 1'b1;
          ent_raddr = idx_r[AW-1:0];
          pidx_nxt  = idx_r[AW-1:0];
          idx_nxt   = idx_r + CNT_W'(1);
          pend_nxt  = 1'b1;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r) begin
          if (st_new != rd_st) begin
            ent_we    = 1'b1;
            ent_waddr = pidx_r;
            ent_wdata = {rd_node, rd_hnd, st_new};
          end
          if ((cmd_r == CMD_PICK && st_new != rd_st) ||
              (cmd_r == CMD_READ && rd_st == STS_RESP && res_n_r < lim_r)) begin
            res_we    = 1'b1;
            res_n_nxt = res_n_r + RES_CW'(1);
          end
          if (cmd_r == CMD_PICK && st_new != rd_st) begin
            pick_fly_nxt = pick_fly_r + CNT_W'(1);
            rpc_nxt      = rpc_r + CTR_W'(1);
          end
          if (st_new == STS_FLY)  fly_acc_nxt  = fly_acc_r + CNT_W'(1);
          if (st_new == STS_RESP) resp_acc_nxt = resp_acc_r + CNT_W'(1);
          if (st_new == STS_UNQ)  unq_acc_nxt  = unq_acc_r + CNT_W'(1);
          if (CW'(seen_r) < CW'(k_r)) begin
            seen_nxt = seen_r + CNT_W'(1);
            if (st_new == STS_UNQ)  preunq_nxt = 1'b1;
            if (st_new == STS_RESP) respk_nxt  = respk_r + CNT_W'(1);
          end
        end else if (idx_r == total_r) begin
          fly_nxt  = fly_acc_r;
          flyo_nxt = (CW'(fly_acc_r) > CW'(FLY_SAT)) ? FLY_W'(FLY_SAT) : FLY_W'(fly_acc_r);
          succ_nxt = (resp_acc_r != '0);
          comp_nxt = (fly_acc_r == '0) && !preunq_r &&
                     ((CW'(respk_r) >= CW'(k_r)) || (unq_acc_r == '0));
          if (cmd_r == CMD_PICK && res_n_r != '0) round_nxt = round_r + CTR_W'(1);
          e_nxt     = '0;
          state_nxt = S_EMIT_RD;
        end
      end

      S_EMIT_RD: begin
        if (res_n_r == '0) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = {tail, (HANDLE_W + ID_W)'(0)};
            out_user_nxt  = {1'b0, KIND_STATUS};
            out_last_nxt  = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else begin
          res_re    = 1'b1;
          state_nxt = S_EMIT_LD;
        end
      end

      S_EMIT_LD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {tail, HANDLE_W'(res_rdata[HS_W-1:0]),
                           ID_W'(res_rdata[RW-1 -: IW])};
          out_user_nxt  = {1'b1, (cmd_r == CMD_PICK) ? KIND_PICK : KIND_CLOSEST};
          out_last_nxt  = emit_last;
          if (emit_last) begin
            state_nxt = S_IDLE;
          end else begin
            e_nxt     = e_r + RES_AW'(1);
            state_nxt = S_EMIT_RD;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    // advance the insertion sort to the next key
    if (next_i) begin
      if (i_r + CNT_W'(1) < total_r) begin
        ent_re    = 1'b1;
        ent_raddr = AW'(i_r + CNT_W'(1));
        i_nxt     = i_r + CNT_W'(1);
        state_nxt = S_SRT_KEY;
      end else begin
        state_nxt = S_IDLE;
      end
    end

    // open a status pass
    if (start_main) begin
      state_nxt    = S_MAIN;
      idx_nxt      = '0;
      pend_nxt     = 1'b0;
      pick_fly_nxt = fly_r;
      fly_acc_nxt  = '0;
      resp_acc_nxt = '0;
      unq_acc_nxt  = '0;
      seen_nxt     = '0;
      respk_nxt    = '0;
      preunq_nxt   = 1'b0;
      res_n_nxt    = '0;
    end
  end

  // state and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      rpc_r       <= '0;
      round_r     <= '0;
      fly_r       <= '0;
      target_r    <= '0;
      local_r     <= '0;
      par_r       <= PAR_W'(3);
      k_r         <= K_W'(20);
      pend_r      <= 1'b0;
      res_n_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      total_r     <= total_nxt;
      rpc_r       <= rpc_nxt;
      round_r     <= round_nxt;
      fly_r       <= fly_nxt;
      target_r    <= target_nxt;
      local_r     <= local_nxt;
      par_r       <= par_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      res_n_r     <= res_n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and working registers
  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    pid_r      <= pid_nxt;
    ph_r       <= ph_nxt;
    lim_r      <= lim_nxt;
    idx_r      <= idx_nxt;
    pidx_r     <= pidx_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    key_r      <= key_nxt;
    dup_r      <= dup_nxt;
    found_r    <= found_nxt;
    pos_r      <= pos_nxt;
    over_r     <= over_nxt;
    ins_n_r    <= ins_n_nxt;
    rem_r      <= rem_nxt;
    pick_fly_r <= pick_fly_nxt;
    fly_acc_r  <= fly_acc_nxt;
    resp_acc_r <= resp_acc_nxt;
    unq_acc_r  <= unq_acc_nxt;
    seen_r     <= seen_nxt;
    respk_r    <= respk_nxt;
    preunq_r   <= preunq_nxt;
    e_r        <= e_nxt;
    comp_r     <= comp_nxt;
    succ_r     <= succ_nxt;
    flyo_r     <= flyo_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
    out_last_r <= out_last_nxt;
  end

`ifndef SYNTHESIS
  // table never holds more than its capacity
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  // picks never push the in-flight count past the alpha cap (MAX_ALPHA)
  a_fly_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(fly_r) <= CW'(MAX_ALPHA))
    else $error("in-flight count above alpha limit");

  // an accepted request makes the core busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> !in_tready)
    else $error("request accepted while still working");

  // result buffer count stays within its depth
  a_res_n: assert property (@(posedge clk) disable iff (!rst_n)
    res_n_r <= RES_CW'(MAX_RES))
    else $error("result count above buffer depth");
`endif

endmodule

### dv/tb.sv
// Self-checking testbench for xor_distance_shortlist_core: directed table, then random
// lookup traffic, all results checked against an in-bench shortlist predictor.
// Depends on xds_pkg and the RTL of the core.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import xds_pkg::*;

  localparam int SLOTS = 64;
  localparam int ALPHA_CAP = 16;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic                pv;
    logic                last;
    logic                comp;
    logic [FLY_W-1:0]    fly;
    logic                succ;
    logic                over;
    logic [CTR_W-1:0]    rpc;
    logic [CTR_W-1:0]    rounds;
  } lookup_res_t;

  typedef struct {
    logic [CMD_W-1:0]    cmd;
    logic [ID_W-1:0]     id;
    logic [HANDLE_W-1:0] handle;
    logic [CC_W-1:0]     cc;
    bit                  typed;  // expect an empty status report, table complete
  } drow_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [IN_USER_W-1:0]  in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;
  logic                  out_tlast;
  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0]     cfg_paddr = '0;
  logic [CFG_DW-1:0]     cfg_pwdata = '0;
  logic [CFG_DW-1:0]     cfg_prdata;
  logic                  cfg_pready;

  xor_distance_shortlist_core uut (.*);

  always #5 clk = ~clk;

  // shortlist mirror
  logic [ID_W-1:0]     sl_id[SLOTS];
  logic [HANDLE_W-1:0] sl_h[SLOTS];
  logic [1:0]          sl_st[SLOTS];
  int                  sl_n = 0;
  logic [CTR_W-1:0]    rpc_cnt = '0, round_cnt = '0;
  logic [ID_W-1:0]     tgt = '0, self_id = '0;
  logic [PAR_W-1:0]    alpha = 5'd3;
  logic [K_W-1:0]      kc = 7'd20;

  lookup_res_t pending_q[$];
  int fails = 0;
  int got = 0;

  function automatic logic [ID_W-1:0] xdist(logic [ID_W-1:0] id);
    return id ^ tgt;
  endfunction

  function automatic int locate(logic [ID_W-1:0] id);
    for (int i = 0; i < sl_n; i++) if (sl_id[i] == id) return i;
    return -1;
  endfunction

  function automatic int count_st(logic [1:0] st);
    int c;
    c = 0;
    for (int i = 0; i < sl_n; i++) if (sl_st[i] == st) c++;
    return c;
  endfunction

  function automatic bit lookup_done();
    int resp, seen;
    resp = 0;
    seen = 0;
    if (count_st(STS_FLY) > 0) return 1'b0;
    for (int i = 0; i < sl_n; i++) begin
      if (seen >= kc) break;
      if (sl_st[i] == STS_UNQ) return 1'b0;
      if (sl_st[i] == STS_RESP) resp++;
      seen++;
    end
    if (resp >= kc) return 1'b1;
    return count_st(STS_UNQ) == 0;
  endfunction

  // insertion sort by distance to the new target
  task automatic resort_shortlist();
    logic [ID_W-1:0] id;
    logic [HANDLE_W-1:0] h;
    logic [1:0] st;
    int j;
    for (int i = 1; i < sl_n; i++) begin
      id = sl_id[i]; h = sl_h[i]; st = sl_st[i];
      j = i;
      while (j > 0 && xdist(sl_id[j-1]) > xdist(id)) begin
        sl_id[j] = sl_id[j-1]; sl_h[j] = sl_h[j-1]; sl_st[j] = sl_st[j-1];
        j--;
      end
      sl_id[j] = id; sl_h[j] = h; sl_st[j] = st;
    end
  endtask

  // returns 1 when a full table dropped an entry
  function automatic bit admit_peer(logic [ID_W-1:0] id, logic [HANDLE_W-1:0] h);
    logic [ID_W-1:0] d;
    int pos;
    bit over;
    over = 1'b0;
    if (id == self_id || locate(id) >= 0) return 1'b0;
    d = xdist(id);
    if (sl_n >= SLOTS) begin
      over = 1'b1;
      if (d > xdist(sl_id[SLOTS-1])) return 1'b1;
      sl_n = SLOTS - 1;
    end
    pos = 0;
    while (pos < sl_n && xdist(sl_id[pos]) < d) pos++;
    for (int i = sl_n; i > pos; i--) begin
      sl_id[i] = sl_id[i-1]; sl_h[i] = sl_h[i-1]; sl_st[i] = sl_st[i-1];
    end
    sl_id[pos] = id; sl_h[pos] = h; sl_st[pos] = STS_UNQ;
    sl_n++;
    return over;
  endfunction

  // apply one request to the mirror and queue the results it causes
  task automatic predict_request(drow_t r);
    logic [ID_W-1:0] rid[$];
    logic [HANDLE_W-1:0] rh[$];
    logic [KIND_W-1:0] kind;
    lookup_res_t e;
    bit over;
    int a, fly, lim, idx, nres;
    over = 1'b0;
    kind = KIND_STATUS;
    case (r.cmd) inside
      CMD_ADD: over = admit_peer(r.id, r.handle);
      CMD_PICK: begin
        a = (alpha == 0) ? 1 : (alpha > ALPHA_CAP ? ALPHA_CAP : alpha);
        fly = count_st(STS_FLY);
        kind = KIND_PICK;
        for (int i = 0; i < sl_n && fly < a; i++) begin
          if (sl_st[i] == STS_UNQ) begin
            sl_st[i] = STS_FLY;
            rid = {rid, sl_id[i]}; rh = {rh, sl_h[i]};
            fly++;
            rpc_cnt++;
          end
        end
        if (rid.size() > 0) round_cnt++;
      end
      CMD_RESP, CMD_FAIL: begin
        idx = locate(r.id);
        if (idx >= 0) sl_st[idx] = (r.cmd == CMD_RESP) ? STS_RESP : STS_FAIL;
      end
      CMD_READ: begin
        lim = (r.cc > MAX_RES) ? MAX_RES : r.cc;
        kind = KIND_CLOSEST;
        for (int i = 0; i < sl_n && rid.size() < lim; i++) begin
          if (sl_st[i] == STS_RESP) begin
            rid = {rid, sl_id[i]}; rh = {rh, sl_h[i]};
          end
        end
      end
      default: ;
    endcase
    fly = count_st(STS_FLY);
    e.comp = lookup_done();
    e.fly = FLY_W'((fly > FLY_SAT) ? FLY_SAT : fly);
    e.succ = count_st(STS_RESP) > 0;
    e.over = over;
    e.rpc = rpc_cnt;
    e.rounds = round_cnt;
    nres = (rid.size() > 0) ? rid.size() : 1;
    for (int i = 0; i < nres; i++) begin
      e.pv = rid.size() > 0;
      e.kind = e.pv ? kind : KIND_STATUS;
      e.id = e.pv ? rid[i] : '0;
      e.handle = e.pv ? rh[i] : '0;
      e.last = (i == nres - 1);
      if (r.typed) begin
        // nothing stored yet: empty report, lookup trivially complete
        e = '0;
        e.last = 1'b1;
        e.comp = 1'b1;
      end
      pending_q = {pending_q, e};
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // APB write: setup, then access; mirror updated once the write lands
  task automatic reg_write(logic [1:0] idx, logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1; cfg_penable <= 1'b0; cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(idx) << 3; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0; cfg_penable <= 1'b0; cfg_pwrite <= 1'b0;
    case (idx)
      REG_TARGET: begin tgt = val[ID_W-1:0]; resort_shortlist(); end
      REG_LOCAL: self_id = val[ID_W-1:0];
      REG_PAR: alpha = val[PAR_W-1:0];
      REG_K: kc = val[K_W-1:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // offer one request, hold it until accepted
  task automatic send_request(drow_t r, int gap);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= r.cmd;
    in_tdata <= {1'b0, r.cc, r.handle, r.id};
    do @(posedge clk); while (!in_tready);
    predict_request(r);
  endtask

  function automatic drow_t mk(logic [CMD_W-1:0] c, logic [ID_W-1:0] id,
                               logic [HANDLE_W-1:0] h, logic [CC_W-1:0] cc, bit typed);
    drow_t r;
    r.cmd = c; r.id = id; r.handle = h; r.cc = cc; r.typed = typed;
    return r;
  endfunction

  // random request; responses and failures mostly aimed at peers already in the shortlist
  function automatic drow_t rand_request();
    drow_t r;
    int w, pick;
    r = mk(CMD_ADD, {$urandom, $urandom}, HANDLE_W'({$urandom, $urandom}),
           CC_W'($urandom_range(0, 127)), 0);
    w = $urandom_range(0, 99);
    if (w < 40) r.cmd = CMD_ADD;
    else if (w < 60) r.cmd = CMD_PICK;
    else if (w < 75) r.cmd = CMD_RESP;
    else if (w < 85) r.cmd = CMD_FAIL;
    else r.cmd = CMD_READ;
    if (sl_n > 0 && (r.cmd == CMD_RESP || r.cmd == CMD_FAIL || $urandom_range(0, 9) == 0)
        && $urandom_range(0, 9) != 0) begin
      pick = $urandom_range(0, sl_n - 1);
      for (int i = 0; i < sl_n; i++)
        if (sl_st[i] == STS_FLY && $urandom_range(0, 1)) pick = i;
      r.id = sl_id[pick];
    end else if ($urandom_range(0, 19) == 0) begin
      r.id = self_id;
    end
    return r;
  endfunction

  // result checker
  function automatic void cmp_field(string name, logic [63:0] exp, logic [63:0] act);
    if (exp !== act) begin
      $error("%s expected %h actual %h", name, exp, act);
      fails++;
    end
  endfunction

  int stall = 0;
  int cyc = 0;
  bit calm = 1'b0;
  bit held = 1'b0;
  always begin
    lookup_res_t e;
    bit rdy;
    if (!held && got >= 40) begin
      // long hold so the core backs up into the input
      held = 1'b1;
      out_tready <= 1'b0;
      repeat (400) @(posedge clk);
    end
    if (cyc % 64 == 0) calm = ($urandom_range(0, 3) == 0);
    cyc++;
    rdy = (stall == 0);
    if (stall > 0) stall--;
    else stall = calm ? 0 : gap_len();
    out_tready <= rdy;
    @(posedge clk);
    if (rst_n && out_tvalid && out_tready) begin
      got++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: tdata %h", out_tdata);
        fails++;
      end else begin
        e = pending_q.pop_front();
        cmp_field("kind", e.kind, out_tuser[1:0]);
        cmp_field("peer_valid", e.pv, out_tuser[2]);
        cmp_field("last", e.last, out_tlast);
        cmp_field("out_id", e.id, out_tdata[63:0]);
        cmp_field("out_handle", e.handle, out_tdata[111:64]);
        cmp_field("complete", e.comp, out_tdata[112]);
        cmp_field("inflight_now", e.fly, out_tdata[117:113]);
        cmp_field("success", e.succ, out_tdata[118]);
        cmp_field("overflowed", e.over, out_tdata[119]);
        cmp_field("rpc_total", e.rpc, out_tdata[151:120]);
        cmp_field("pick_rounds", e.rounds, out_tdata[183:152]);
      end
    end
  end

  initial begin
    #100ms;
    $display("tb: failure");
    $finish;
  end

  initial begin
    drow_t dir[$];
    int items;
    int plen;
    bit burst;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // directed table, default registers
    dir = {dir, mk(CMD_PICK, '0, '0, 7'd1, 1)};             // pick on empty table
    dir = {dir, mk(CMD_READ, '0, '0, 7'd64, 1)};            // read on empty table
    dir = {dir, mk(CMD_ADD, '0, 48'h1, 7'd1, 1)};           // self rejected
    dir = {dir, mk(CMD_RESP, 64'h55, '0, 7'd1, 1)};         // unknown peer
    dir = {dir, mk(CMD_FAIL, 64'h66, '0, 7'd1, 1)};         // unknown peer
    dir = {dir, mk(CMD_ADD, '1, '1, 7'd64, 0)};
    dir = {dir, mk(CMD_ADD, 64'h1, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_ADD, 64'h1, 48'hABC, 7'd1, 0)};      // duplicate
    dir = {dir, mk(CMD_ADD, 64'h2, 48'h2, 7'd1, 0)};
    dir = {dir, mk(CMD_ADD, 64'h8000_0000_0000_0000, 48'h8000_0000_0000, 7'd1, 0)};
    dir = {dir, mk(CMD_ADD, 64'h3, 48'h3, 7'd1, 0)};
    dir = {dir, mk(CMD_PICK, '0, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_PICK, '0, '0, 7'd1, 0)};             // already at alpha
    dir = {dir, mk(CMD_RESP, 64'h1, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_FAIL, 64'h2, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_READ, '0, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_PICK, '0, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_RESP, 64'h3, '0, 7'd64, 0)};
    dir = {dir, mk(CMD_RESP, 64'h1, '0, 7'd1, 0)};          // responded again
    dir = {dir, mk(CMD_FAIL, 64'h1, '0, 7'd1, 0)};          // responded then failed
    dir = {dir, mk(CMD_RESP, '1, '0, 7'd1, 0)};
    dir = {dir, mk(CMD_READ, '0, '0, 7'd64, 0)};
    foreach (dir[i]) send_request(dir[i], gap_len());
    in_tvalid <= 1'b0;
    drain();

    // every register once, extremes first
    reg_write(REG_TARGET, '1);
    reg_write(REG_LOCAL, '1);
    reg_write(REG_PAR, 64'd16);
    reg_write(REG_K, 64'd1);

    // random phases, registers changed between them
    items = 0;
    while (items < 288) begin
      plen = $urandom_range(20, 45);
      if (plen > 288 - items) plen = 288 - items;
      burst = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < plen; i++) begin
        send_request(rand_request(), burst ? 0 : gap_len());
        items++;
      end
      in_tvalid <= 1'b0;
      drain();
      case ($urandom_range(0, 3))
        0: reg_write(REG_TARGET, $urandom_range(0, 3) == 0 ? 64'd0 : {$urandom, $urandom});
        1: reg_write(REG_LOCAL, (sl_n > 0) ? sl_id[$urandom_range(0, sl_n - 1)]
                                           : {$urandom, $urandom});
        2: reg_write(REG_PAR, $urandom_range(0, 1) ? 64'($urandom_range(0, 1) ? 1 : 16)
                                                   : 64'($urandom_range(1, 16)));
        default: reg_write(REG_K, $urandom_range(0, 1) ? 64'($urandom_range(0, 1) ? 1 : 64)
                                                       : 64'($urandom_range(1, 64)));
      endcase
    end

    drain();
    repeat (200) @(posedge clk);
    if (fails == 0 && pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
